### design/evpn_nlri_field_extractor_assert.svh
// assertion macros shared by the checker of the evpn nlri field extractor
// depends on nothing; included by files that hold concurrent assertions
`ifndef EVPN_NLRI_FIELD_EXTRACTOR_ASSERT_SVH
`define EVPN_NLRI_FIELD_EXTRACTOR_ASSERT_SVH

// same-cycle implication, disabled while reset is low
`define EVPN_ASSERT_NOW(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("evpn checker: property violated");

// next-cycle implication, disabled while reset is low
`define EVPN_ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("evpn checker: property violated");

`endif

### design/evpn_pkg.sv
// shared types and codes for the evpn nlri field extractor
// depends on nothing
package evpn_pkg;

    localparam int TDATA_W = 424;

    localparam logic [1:0] ST_COMPLETE = 2'd0;
    localparam logic [1:0] ST_CUT      = 2'd1;
    localparam logic [1:0] ST_UNKNOWN  = 2'd2;

    localparam logic [7:0] RT_AD       = 8'd1;
    localparam logic [7:0] RT_MAC_IP   = 8'd2;
    localparam logic [7:0] RT_MCAST    = 8'd3;
    localparam logic [7:0] RT_SEGMENT  = 8'd4;

    // one finished route record
    typedef struct packed {
        logic [7:0]  rt_code;
        logic [63:0] rd_value;
        logic [63:0] esi_head;
        logic [15:0] esi_tail;
        logic [31:0] ethernet_tag;
        logic [7:0]  mac_length;
        logic [47:0] mac_address;
        logic [7:0]  ip_length;
        logic [63:0] ip_high;
        logic [63:0] ip_low;
        logic [47:0] labels;
        logic [1:0]  status;
    } rec_t;

endpackage

### design/evpn_parse_core.sv
// byte-wise route parser: phase tracking, field accumulators and record build
// depends on evpn_pkg
module evpn_parse_core
    import evpn_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       take,
    input  logic [7:0] data_byte,
    input  logic       end_of_data,
    output logic       emit,
    output rec_t       rec
);

    typedef enum logic [2:0] {
        PH_TYPE = 3'b001,
        PH_LEN  = 3'b010,
        PH_BODY = 3'b100
    } phase_t;

    typedef struct packed {
        logic [63:0] rd;
        logic [63:0] esi_h;
        logic [15:0] esi_t;
        logic [31:0] tag;
        logic [7:0]  mac_len;
        logic [47:0] mac;
        logic [7:0]  ip_len;
        logic [4:0]  addr_cnt;
        logic [63:0] ip_hi;
        logic [63:0] ip_lo;
        logic [47:0] lab;
    } acc_t;

    phase_t     phase_reg, phase_next;
    logic [7:0] pos_reg, pos_next;
    logic [7:0] len_reg, len_next;
    logic [7:0] type_reg, type_next;
    acc_t       acc_reg, acc_next, acc_upd;
    logic [1:0] status;

    // byte idx of a big-endian field, 0 topmost
    function automatic logic [63:0] place8(input logic [2:0] idx, input logic [7:0] b);
        place8 = {56'd0, b} << {3'd7 - idx, 3'd0};
    endfunction

    function automatic logic [47:0] place6(input logic [2:0] idx, input logic [7:0] b);
        place6 = {40'd0, b} << {3'd5 - idx, 3'd0};
    endfunction

    function automatic logic [31:0] place4(input logic [1:0] idx, input logic [7:0] b);
        place4 = {24'd0, b} << {2'd3 - idx, 3'd0};
    endfunction

    // address byte at offset k from the start of the address region
    function automatic acc_t put_ip(input acc_t a, input logic [7:0] pos,
                                    input logic [7:0] start, input logic [7:0] b);
        logic [7:0] k;
        acc_t       r;
        r = a;
        k = pos - start;
        if (pos >= start && k < {3'd0, a.addr_cnt} && k < 8'd16) begin
            if (k[3]) begin
                r.ip_lo = a.ip_lo | place8(k[2:0], b);
            end else begin
                r.ip_hi = a.ip_hi | place8(k[2:0], b);
            end
        end
        return r;
    endfunction

    logic       known;
    logic [7:0] pos_inc;
    logic [7:0] off;
    logic [7:0] lab_start;
    logic [7:0] lab_off;

    assign known = (type_reg >= RT_AD) && (type_reg <= RT_SEGMENT);
    assign pos_inc = pos_reg + 8'd1;
    assign lab_start = 8'd30 + {3'd0, acc_reg.addr_cnt};
    assign lab_off = pos_reg - lab_start;

    // field placement of one body byte
    always_comb begin
        acc_upd = acc_reg;
        off = 8'd0;
        if (pos_reg < 8'd8) begin
            acc_upd.rd = acc_reg.rd | place8(pos_reg[2:0], data_byte);
        end else if (type_reg != RT_MCAST && pos_reg < 8'd18) begin
            off = pos_reg - 8'd8;
            if (off < 8'd8) begin
                acc_upd.esi_h = acc_reg.esi_h | place8(off[2:0], data_byte);
            end else if (off == 8'd8) begin
                acc_upd.esi_t = acc_reg.esi_t | {data_byte, 8'd0};
            end else begin
                acc_upd.esi_t = acc_reg.esi_t | {8'd0, data_byte};
            end
        end else begin
            unique case (type_reg)
                RT_AD: begin
                    if (pos_reg < 8'd22) begin
                        off = pos_reg - 8'd18;
                        acc_upd.tag = acc_reg.tag | place4(off[1:0], data_byte);
                    end else if (pos_reg < 8'd25) begin
                        off = pos_reg - 8'd22;
                        acc_upd.lab = acc_reg.lab | place6(off[2:0], data_byte);
                    end
                end
                RT_MAC_IP: begin
                    if (pos_reg < 8'd22) begin
                        off = pos_reg - 8'd18;
                        acc_upd.tag = acc_reg.tag | place4(off[1:0], data_byte);
                    end else if (pos_reg == 8'd22) begin
                        acc_upd.mac_len = data_byte;
                    end else if (pos_reg < 8'd29) begin
                        off = pos_reg - 8'd23;
                        acc_upd.mac = acc_reg.mac | place6(off[2:0], data_byte);
                    end else if (pos_reg == 8'd29) begin
                        acc_upd.ip_len = data_byte;
                        acc_upd.addr_cnt = data_byte[7:3];
                    end else begin
                        acc_upd = put_ip(acc_reg, pos_reg, 8'd30, data_byte);
                        if (pos_reg >= lab_start && lab_off < 8'd6) begin
                            acc_upd.lab = acc_reg.lab | place6(lab_off[2:0], data_byte);
                        end
                    end
                end
                RT_MCAST: begin
                    if (pos_reg < 8'd12) begin
                        off = pos_reg - 8'd8;
                        acc_upd.tag = acc_reg.tag | place4(off[1:0], data_byte);
                    end else if (pos_reg == 8'd12) begin
                        acc_upd.ip_len = data_byte;
                        acc_upd.addr_cnt = data_byte[7:3];
                    end else begin
                        acc_upd = put_ip(acc_reg, pos_reg, 8'd13, data_byte);
                    end
                end
                default: begin
                    if (pos_reg == 8'd18) begin
                        acc_upd.ip_len = data_byte;
                        acc_upd.addr_cnt = data_byte[7:3];
                    end else begin
                        acc_upd = put_ip(acc_reg, pos_reg, 8'd19, data_byte);
                    end
                end
            endcase
        end
    end

    // route phase sequencing
    always_comb begin
        phase_next = phase_reg;
        pos_next = pos_reg;
        len_next = len_reg;
        type_next = type_reg;
        acc_next = acc_reg;
        emit = 1'b0;
        status = ST_COMPLETE;
        unique case (phase_reg)
            PH_TYPE: begin
                acc_next = '0;
                type_next = data_byte;
                len_next = 8'd0;
                pos_next = 8'd0;
                phase_next = PH_LEN;
                if (end_of_data) begin
                    emit = 1'b1;
                    status = ST_CUT;
                end
            end
            PH_LEN: begin
                len_next = data_byte;
                pos_next = 8'd0;
                phase_next = PH_BODY;
                if (data_byte == 8'd0) begin
                    emit = 1'b1;
                    status = known ? ST_COMPLETE : ST_UNKNOWN;
                end else if (end_of_data) begin
                    emit = 1'b1;
                    status = ST_CUT;
                end
            end
            default: begin
                if (known) begin
                    acc_next = acc_upd;
                end
                pos_next = pos_inc;
                if (pos_inc == len_reg) begin
                    emit = 1'b1;
                    status = known ? ST_COMPLETE : ST_UNKNOWN;
                end else if (end_of_data) begin
                    emit = 1'b1;
                    status = ST_CUT;
                end
            end
        endcase
    end

    always_comb begin
        rec.rt_code      = type_next;
        rec.rd_value     = acc_next.rd;
        rec.esi_head     = acc_next.esi_h;
        rec.esi_tail     = acc_next.esi_t;
        rec.ethernet_tag = acc_next.tag;
        rec.mac_length   = acc_next.mac_len;
        rec.mac_address  = acc_next.mac;
        rec.ip_length    = acc_next.ip_len;
        rec.ip_high      = acc_next.ip_hi;
        rec.ip_low       = acc_next.ip_lo;
        rec.labels       = acc_next.lab;
        rec.status       = status;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= PH_TYPE;
            pos_reg   <= 8'd0;
            len_reg   <= 8'd0;
            type_reg  <= 8'd0;
            acc_reg   <= '0;
        end else if (take) begin
            len_reg  <= len_next;
            type_reg <= type_next;
            if (emit) begin
                phase_reg <= PH_TYPE;
                pos_reg   <= 8'd0;
                acc_reg   <= '0;
            end else begin
                phase_reg <= phase_next;
                pos_reg   <= pos_next;
                acc_reg   <= acc_next;
            end
        end
    end

endmodule

### design/evpn_nlri_field_extractor.sv
// Parses a BGP EVPN NLRI byte stream, one byte per request on the slave side,
// s_tlast marking the last byte of the block. Each route (type byte, length
// byte, body) yields one record on the master side, registered and shown the
// cycle after the byte that ends the route; m_tuser carries the status
// (complete, cut short by end of data, unknown type skipped). One byte is taken
// every cycle: each byte updates the field accumulators as it is taken, and
// the only stall comes from a record held in the output register while
// m_tready is low. No clearing pass is needed after reset.
module evpn_nlri_field_extractor
    import evpn_pkg::*;
(
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_tvalid,
    output logic               s_tready,
    input  logic [7:0]         s_tdata,   // data_byte
    input  logic               s_tlast,   // end_of_data
    output logic               m_tvalid,
    input  logic               m_tready,
    // rt_code, rd_value, esi_head, esi_tail, ethernet_tag, mac_length,
    // mac_address, ip_length, ip_high, ip_low, labels
    output logic [TDATA_W-1:0] m_tdata,
    output logic [1:0]         m_tuser    // status
);

    logic               take;
    logic               emit;
    rec_t               rec;
    logic               out_free;
    logic               m_tvalid_reg, m_tvalid_next;
    logic [TDATA_W-1:0] m_tdata_reg, m_tdata_next;
    logic [1:0]         m_tuser_reg, m_tuser_next;

    assign out_free = !m_tvalid_reg || m_tready;
    assign s_tready = out_free;
    assign take     = s_tvalid && out_free;

    evpn_parse_core u_core (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .take        (take),
        .data_byte   (s_tdata),
        .end_of_data (s_tlast),
        .emit        (emit),
        .rec         (rec)
    );

    always_comb begin
        m_tvalid_next = m_tvalid_reg;
        m_tdata_next  = m_tdata_reg;
        m_tuser_next  = m_tuser_reg;
        if (out_free) begin
            m_tvalid_next = take && emit;
            m_tdata_next  = {rec.labels, rec.ip_low, rec.ip_high, rec.ip_length,
                             rec.mac_address, rec.mac_length, rec.ethernet_tag,
                             rec.esi_tail, rec.esi_head, rec.rd_value, rec.rt_code};
            m_tuser_next  = rec.status;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else begin
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge aclk) begin
        m_tdata_reg <= m_tdata_next;
        m_tuser_reg <= m_tuser_next;
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

endmodule

### design/evpn_checker.sv
// port-level checker for the evpn nlri field extractor, bound to the top level
// depends on evpn_pkg and evpn_nlri_field_extractor_assert.svh
`include "evpn_nlri_field_extractor_assert.svh"

module evpn_checker
    import evpn_pkg::*;
(
    input logic               aclk,
    input logic               aresetn,
    input logic               s_tvalid,
    input logic               s_tready,
    input logic [7:0]         s_tdata,
    input logic               s_tlast,
    input logic               m_tvalid,
    input logic               m_tready,
    input logic [TDATA_W-1:0] m_tdata,
    input logic [1:0]         m_tuser
);

    logic [7:0] out_type;
    logic       last_in;

    assign out_type = m_tdata[7:0];
    assign last_in  = s_tvalid && s_tready && s_tlast && (s_tdata == s_tdata);

    // a stalled record holds
    `EVPN_ASSERT_NEXT(a_hold_valid, aclk, aresetn, m_tvalid && !m_tready, m_tvalid)
    `EVPN_ASSERT_NEXT(a_hold_data, aclk, aresetn, m_tvalid && !m_tready, $stable(m_tdata) && $stable(m_tuser))
    // input is only held off by a waiting record
    `EVPN_ASSERT_NOW(a_ready_free, aclk, aresetn, !m_tvalid, s_tready)
    // the last byte of a block always closes a route
    `EVPN_ASSERT_NEXT(a_last_emits, aclk, aresetn, last_in, m_tvalid)
    // skipped routes only carry types outside the known set
    `EVPN_ASSERT_NOW(a_unknown_type, aclk, aresetn, m_tvalid && m_tuser == ST_UNKNOWN, out_type < RT_AD || out_type > RT_SEGMENT)

endmodule

bind evpn_nlri_field_extractor evpn_checker u_evpn_checker (.*);

### dv/evpn_nlri_field_extractor_checker.sv
// route record checker for the evpn nlri field extractor: parses the accepted byte stream,
// queues the records it predicts and compares them with the records seen on the master side
// depends on evpn_pkg for the record type, route type and status codes
`timescale 1ns / 1ps

module evpn_nlri_field_extractor_checker
    import evpn_pkg::*;
(
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_tvalid,
    input  logic               s_tready,
    input  logic [7:0]         s_tdata,
    input  logic               s_tlast,
    input  logic               m_tvalid,
    input  logic               m_tready,
    input  logic [TDATA_W-1:0] m_tdata,
    input  logic [1:0]         m_tuser,
    output int                 fail_count,
    output int                 routes_pending,
    output int                 routes_seen,
    output int                 cut_routes,
    output int                 skipped_routes
);

    typedef enum logic [2:0] {
        WAIT_TYPE = 3'b001,
        WAIT_LEN  = 3'b010,
        IN_BODY   = 3'b100
    } parse_phase_t;

    parse_phase_t phase;
    logic [7:0]   body_pos;
    logic [7:0]   route_len;
    logic [7:0]   cur_type;
    logic [4:0]   addr_cnt;
    logic [63:0]  rd_acc;
    logic [63:0]  esi_head_acc;
    logic [15:0]  esi_tail_acc;
    logic [31:0]  tag_acc;
    logic [7:0]   mac_len_acc;
    logic [47:0]  mac_acc;
    logic [7:0]   ip_len_acc;
    logic [63:0]  ip_high_acc;
    logic [63:0]  ip_low_acc;
    logic [47:0]  label_acc;

    rec_t expected_routes[$];

    function automatic bit is_known_type(input logic [7:0] t);
        return t >= RT_AD && t <= RT_SEGMENT;
    endfunction

    task automatic clear_route_fields();
        addr_cnt     = '0;
        rd_acc       = '0;
        esi_head_acc = '0;
        esi_tail_acc = '0;
        tag_acc      = '0;
        mac_len_acc  = '0;
        mac_acc      = '0;
        ip_len_acc   = '0;
        ip_high_acc  = '0;
        ip_low_acc   = '0;
        label_acc    = '0;
    endtask

    task automatic close_route(input logic [1:0] st);
        rec_t r;
        r.rt_code      = cur_type;
        r.rd_value     = rd_acc;
        r.esi_head     = esi_head_acc;
        r.esi_tail     = esi_tail_acc;
        r.ethernet_tag = tag_acc;
        r.mac_length   = mac_len_acc;
        r.mac_address  = mac_acc;
        r.ip_length    = ip_len_acc;
        r.ip_high      = ip_high_acc;
        r.ip_low       = ip_low_acc;
        r.labels       = label_acc;
        r.status       = st;
        expected_routes.push_back(r);
        clear_route_fields();
        phase    = WAIT_TYPE;
        body_pos = '0;
    endtask

    task automatic take_ip_length(input logic [7:0] b);
        ip_len_acc = b;
        addr_cnt   = b[7:3];
    endtask

    // k counts from the first address byte; bytes past 16 are dropped
    task automatic store_addr_byte(input int k, input logic [7:0] b);
        if (k >= 0 && k < addr_cnt && k < 16) begin
            if (k < 8)
                ip_high_acc[8*(7-k) +: 8] = b;
            else
                ip_low_acc[8*(15-k) +: 8] = b;
        end
    endtask

    task automatic store_body_byte(input int pos, input logic [7:0] b);
        int k;
        int lab_start;
        if (pos < 8) begin
            rd_acc[8*(7-pos) +: 8] = b;
        end else if (cur_type != RT_MCAST && pos < 18) begin
            k = pos - 8;
            if (k < 8)
                esi_head_acc[8*(7-k) +: 8] = b;
            else
                esi_tail_acc[8*(9-k) +: 8] = b;
        end else if (cur_type == RT_AD) begin
            if (pos < 22)
                tag_acc[8*(21-pos) +: 8] = b;
            else if (pos < 25)
                label_acc[8*(27-pos) +: 8] = b;
        end else if (cur_type == RT_MAC_IP) begin
            if (pos < 22) begin
                tag_acc[8*(21-pos) +: 8] = b;
            end else if (pos == 22) begin
                mac_len_acc = b;
            end else if (pos < 29) begin
                mac_acc[8*(28-pos) +: 8] = b;
            end else if (pos == 29) begin
                take_ip_length(b);
            end else begin
                store_addr_byte(pos - 30, b);
                // labels follow the address, wherever it ends
                lab_start = 30 + addr_cnt;
                if (pos >= lab_start && pos - lab_start < 6)
                    label_acc[8*(5-(pos-lab_start)) +: 8] = b;
            end
        end else if (cur_type == RT_MCAST) begin
            if (pos < 12)
                tag_acc[8*(11-pos) +: 8] = b;
            else if (pos == 12)
                take_ip_length(b);
            else
                store_addr_byte(pos - 13, b);
        end else begin
            if (pos == 18)
                take_ip_length(b);
            else
                store_addr_byte(pos - 19, b);
        end
    endtask

    task automatic parse_nlri_byte(input logic [7:0] b, input logic eod);
        logic [1:0] done_st;
        if (phase == WAIT_TYPE) begin
            clear_route_fields();
            cur_type  = b;
            route_len = '0;
            body_pos  = '0;
            phase     = WAIT_LEN;
            if (eod)
                close_route(ST_CUT);
        end else begin
            done_st = is_known_type(cur_type) ? ST_COMPLETE : ST_UNKNOWN;
            if (phase == WAIT_LEN) begin
                route_len = b;
                body_pos  = '0;
                phase     = IN_BODY;
                if (b == 8'd0)
                    close_route(done_st);
                else if (eod)
                    close_route(ST_CUT);
            end else begin
                if (is_known_type(cur_type))
                    store_body_byte(int'(body_pos), b);
                body_pos = body_pos + 8'd1;
                if (body_pos == route_len)
                    close_route(done_st);
                else if (eod)
                    close_route(ST_CUT);
            end
        end
    endtask

    task automatic check_field(input string name, input logic [63:0] want,
                               input logic [63:0] got);
        if (got !== want) begin
            $error("route record %0d, %s: expected %0h, actual %0h",
                   routes_seen, name, want, got);
            fail_count++;
        end
    endtask

    task automatic compare_route();
        rec_t want;
        want = expected_routes.pop_front();
        check_field("rt_code",      want.rt_code,      m_tdata[7:0]);
        check_field("rd_value",     want.rd_value,     m_tdata[71:8]);
        check_field("esi_head",     want.esi_head,     m_tdata[135:72]);
        check_field("esi_tail",     want.esi_tail,     m_tdata[151:136]);
        check_field("ethernet_tag", want.ethernet_tag, m_tdata[183:152]);
        check_field("mac_length",   want.mac_length,   m_tdata[191:184]);
        check_field("mac_address",  want.mac_address,  m_tdata[239:192]);
        check_field("ip_length",    want.ip_length,    m_tdata[247:240]);
        check_field("ip_high",      want.ip_high,      m_tdata[311:248]);
        check_field("ip_low",       want.ip_low,       m_tdata[375:312]);
        check_field("labels",       want.labels,       m_tdata[423:376]);
        check_field("status",       want.status,       m_tuser);
        if (want.status == ST_CUT)
            cut_routes++;
        if (want.status == ST_UNKNOWN)
            skipped_routes++;
    endtask

    always @(posedge aclk) begin
        if (!aresetn) begin
            phase     = WAIT_TYPE;
            body_pos  = '0;
            route_len = '0;
            cur_type  = '0;
            clear_route_fields();
            expected_routes.delete();
            fail_count     = 0;
            routes_seen    = 0;
            cut_routes     = 0;
            skipped_routes = 0;
        end else begin
            if (s_tvalid && s_tready)
                parse_nlri_byte(s_tdata, s_tlast);
            // the record of this edge's byte shows only after the edge, so the
            // head of the queue is always the older one
            if (m_tvalid && m_tready) begin
                if (expected_routes.size() == 0) begin
                    $error("route record with nothing expected: type %0h, status %0d",
                           m_tdata[7:0], m_tuser);
                    fail_count++;
                end else begin
                    compare_route();
                end
                routes_seen++;
            end
        end
        routes_pending = expected_routes.size();
    end

endmodule

### dv/evpn_nlri_field_extractor_tb.sv
// top of the evpn nlri field extractor testbench: clock, reset, byte stream stimulus
// and output back-pressure; depends on evpn_pkg, the extractor and its route record checker
`timescale 1ns / 1ps

module evpn_nlri_field_extractor_tb;
    import evpn_pkg::*;

    localparam int CYCLE_LIMIT  = 400000;
    localparam int PHASE_BYTES  = 300;
    localparam int LONG_HOLD    = 300;
    localparam int HOLD_ROUTES  = 40;
    localparam int DRAIN_CYCLES = 8;

    logic               aclk     = 1'b0;
    logic               aresetn  = 1'b0;
    logic               s_tvalid = 1'b0;
    logic               s_tready;
    logic [7:0]         s_tdata  = '0;
    logic               s_tlast  = 1'b0;
    logic               m_tvalid;
    logic               m_tready = 1'b0;
    logic [TDATA_W-1:0] m_tdata;
    logic [1:0]         m_tuser;

    int fail_count;
    int routes_pending;
    int routes_seen;
    int cut_routes;
    int skipped_routes;

    int src_idle_pct  = 0;
    int snk_stall_pct = 0;
    bit hold_go       = 1'b0;
    int bytes_sent    = 0;
    int cycle_count   = 0;

    logic [8:0] block_q[$];   // {last, byte}
    logic [7:0] body_q[$];

    evpn_nlri_field_extractor dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    evpn_nlri_field_extractor_checker u_checker (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_tvalid       (s_tvalid),
        .s_tready       (s_tready),
        .s_tdata        (s_tdata),
        .s_tlast        (s_tlast),
        .m_tvalid       (m_tvalid),
        .m_tready       (m_tready),
        .m_tdata        (m_tdata),
        .m_tuser        (m_tuser),
        .fail_count     (fail_count),
        .routes_pending (routes_pending),
        .routes_seen    (routes_seen),
        .cut_routes     (cut_routes),
        .skipped_routes (skipped_routes)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Test completed with failures");
            $finish;
        end
    end

    // output back-pressure; a long hold-off is counted here while the sender carries on
    initial begin : sink_proc
        bit held;
        held = 1'b0;
        forever begin
            @(posedge aclk);
            if (hold_go && !held) begin
                m_tready <= 1'b0;
                repeat (LONG_HOLD - 1) @(posedge aclk);
                held = 1'b1;
            end else begin
                m_tready <= ($urandom_range(99) >= snk_stall_pct);
            end
        end
    end

    function automatic logic [7:0] rand_byte();
        return 8'($urandom_range(255));
    endfunction

    // ready is sampled at the falling edge, where nothing is changing
    task automatic send_byte(input logic [7:0] d, input logic l);
        bit taken;
        while ($urandom_range(99) < src_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= d;
        s_tlast  <= l;
        taken = 1'b0;
        while (!taken) begin
            @(negedge aclk);
            taken = s_tready;
            @(posedge aclk);
        end
        bytes_sent++;
    endtask

    task automatic send_block();
        foreach (block_q[i])
            send_byte(block_q[i][7:0], block_q[i][8]);
        block_q.delete();
    endtask

    task automatic add_body(input int n);
        repeat (n) body_q.push_back(rand_byte());
    endtask

    task automatic add_route();
        int         pick;
        int         len;
        logic [7:0] rt;
        logic [7:0] ip_bits;
        body_q.delete();
        pick = $urandom_range(99);
        if (pick < 72) begin
            rt = 8'($urandom_range(RT_AD, RT_SEGMENT));
            case ($urandom_range(8))
                0, 1:    ip_bits = 8'd0;
                2, 3:    ip_bits = 8'd32;
                4, 5, 6: ip_bits = 8'd128;
                7:       ip_bits = 8'd255;
                default: ip_bits = rand_byte();
            endcase
            add_body(8);
            if (rt == RT_AD) begin
                add_body(10 + 4 + 3);
            end else if (rt == RT_MAC_IP) begin
                add_body(10 + 4);
                body_q.push_back(($urandom_range(3) == 0) ? rand_byte() : 8'd48);
                add_body(6);
                body_q.push_back(ip_bits);
                add_body(int'(ip_bits >> 3));
                add_body($urandom_range(1) ? 3 : 6);
            end else if (rt == RT_MCAST) begin
                add_body(4);
                body_q.push_back(ip_bits);
                add_body(int'(ip_bits >> 3));
            end else begin
                add_body(10);
                body_q.push_back(ip_bits);
                add_body(int'(ip_bits >> 3));
            end
            case ($urandom_range(9))
                0: begin
                    // length stops inside the fields
                    len = $urandom_range(1, body_q.size() - 1);
                    while (body_q.size() > len) void'(body_q.pop_back());
                end
                1: add_body($urandom_range(1, 12));
                default: ;
            endcase
        end else if (pick < 90) begin
            rt = 8'($urandom_range(4, 255));
            if (rt == RT_SEGMENT)
                rt = 8'd0;
            add_body(($urandom_range(19) == 0) ? $urandom_range(100, 255)
                                               : $urandom_range(0, 20));
        end else begin
            rt = 8'($urandom_range(RT_AD, RT_SEGMENT));
        end
        block_q.push_back({1'b0, rt});
        block_q.push_back({1'b0, 8'(body_q.size())});
        foreach (body_q[i])
            block_q.push_back({1'b0, body_q[i]});
    endtask

    task automatic build_block();
        int cut;
        block_q.delete();
        if ($urandom_range(19) == 0) begin
            repeat ($urandom_range(1, 24)) block_q.push_back({1'b0, rand_byte()});
        end else begin
            repeat ($urandom_range(1, 4)) add_route();
        end
        // end of data landing inside a route
        if ($urandom_range(6) == 0 && block_q.size() > 1) begin
            cut = $urandom_range(0, block_q.size() - 2);
            while (block_q.size() > cut + 1) void'(block_q.pop_back());
        end
        block_q[block_q.size() - 1][8] = 1'b1;
    endtask

    task automatic wait_all_routes();
        s_tvalid <= 1'b0;
        do @(negedge aclk); while (routes_pending != 0);
        @(posedge aclk);
    endtask

    task automatic run_phase(input int idle_pct, input int stall_pct);
        int mark;
        src_idle_pct  = idle_pct;
        snk_stall_pct = stall_pct;
        mark = bytes_sent + PHASE_BYTES;
        while (bytes_sent < mark) begin
            build_block();
            send_block();
        end
        wait_all_routes();
    endtask

    initial begin
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;

        // lone type byte at end of data
        send_byte(8'hFF, 1'b1);
        // zero length: record at the length byte
        send_byte(RT_AD, 1'b0);
        send_byte(8'h00, 1'b0);
        // unknown type skipped by its length
        send_byte(8'h00, 1'b0);
        send_byte(8'h02, 1'b0);
        send_byte(8'hA5, 1'b0);
        send_byte(8'h5A, 1'b0);
        // cut short at the length byte
        send_byte(RT_SEGMENT, 1'b0);
        send_byte(8'd5, 1'b1);
        // short length, completing byte carries end of data
        send_byte(RT_MCAST, 1'b0);
        send_byte(8'd3, 1'b0);
        send_byte(8'hFF, 1'b0);
        send_byte(8'h00, 1'b0);
        send_byte(8'h80, 1'b1);
        // zero-length unknown type with end of data
        send_byte(8'hC8, 1'b0);
        send_byte(8'h00, 1'b1);
        // cut short inside the body
        send_byte(RT_MAC_IP, 1'b0);
        send_byte(8'd40, 1'b0);
        send_byte(8'h11, 1'b0);
        send_byte(8'h22, 1'b1);
        wait_all_routes();

        run_phase(0, 0);
        run_phase(76, 0);
        run_phase(0, 76);
        run_phase(13, 13);

        // hold the output off while a run of empty routes piles up behind it
        src_idle_pct  = 0;
        snk_stall_pct = 0;
        hold_go = 1'b1;
        for (int i = 0; i < HOLD_ROUTES; i++) begin
            send_byte(8'($urandom_range(RT_AD, RT_SEGMENT)), 1'b0);
            send_byte(8'h00, i == HOLD_ROUTES - 1);
        end
        wait_all_routes();

        repeat (DRAIN_CYCLES) @(posedge aclk);
        @(negedge aclk);
        $display("run covered %0d nlri bytes and %0d route records (%0d cut short, %0d skipped)",
                 bytes_sent, routes_seen, cut_routes, skipped_routes);
        $display("under four idling mixes and a %0d-cycle output hold-off", LONG_HOLD);
        if (fail_count == 0 && routes_pending == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule

### filelist.f
+incdir+design
design/evpn_pkg.sv
design/evpn_parse_core.sv
design/evpn_nlri_field_extractor.sv
design/evpn_checker.sv
dv/evpn_nlri_field_extractor_checker.sv
dv/evpn_nlri_field_extractor_tb.sv
